FILE: src/gmcu_pkg.sv
// Shared constants, config struct and helpers for the gradient mask coverage block.
package gmcu_pkg;

  localparam int MAX_RASTER_DIM = 4096;
  localparam int PIX_W = 12;
  localparam int COV_W = 8;
  localparam int SQ_W  = 50;   // radicand width
  localparam int RT_W  = 25;   // root width

  localparam logic [16:0] Q16_ONE  = 17'h10000;
  localparam logic [32:0] Q32_ONE  = 33'h1_0000_0000;

  // Register indexes on the write port
  localparam logic [2:0] REG_X_STEP    = 3'd0;
  localparam logic [2:0] REG_Y_STEP    = 3'd1;
  localparam logic [2:0] REG_MASK_MODE = 3'd2;
  localparam logic [2:0] REG_OPACITY   = 3'd3;
  localparam logic [2:0] REG_ANCHOR    = 3'd4;
  localparam logic [2:0] REG_DIRECTION = 3'd5;
  localparam logic [2:0] REG_SCALE     = 3'd6;
  localparam logic [2:0] REG_RAMP      = 3'd7;

  typedef struct packed {
    logic [24:0] x_step;
    logic [24:0] y_step;
    logic [1:0]  mask_mode;
    logic [16:0] opacity;
    logic [63:0] anchor_pair;
    logic [63:0] direction_pair;
    logic [63:0] scale_pair;
    logic [63:0] ramp_pair;
  } cfg_t;

  // Linear result and prior byte riding alongside the square root
  typedef struct packed {
    logic signed [34:0] lin_cov;
    logic [7:0]         prior;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sh0_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -49'sh0_0000_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: src/gmcu_if.sv
// Valid/ready stream interfaces for texel input and coverage output.
interface gmcu_in_if;
  import gmcu_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic [COV_W-1:0] prior_coverage;
  modport source (output valid, pixel_x, pixel_y, prior_coverage, input ready);
  modport sink   (input valid, pixel_x, pixel_y, prior_coverage, output ready);
endinterface

interface gmcu_out_if;
  import gmcu_pkg::*;
  logic             valid;
  logic             ready;
  logic [COV_W-1:0] merged_coverage;
  logic [COV_W-1:0] mask_coverage;
  modport source (output valid, merged_coverage, mask_coverage, input ready);
  modport sink   (input valid, merged_coverage, mask_coverage, output ready);
endinterface

FILE: src/gmcu_cfg.sv
// Configuration register file with write-only port.
module gmcu_cfg
  import gmcu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_step         <= 25'd4096;
      cfg.y_step         <= 25'd4096;
      cfg.mask_mode      <= 2'd0;
      cfg.opacity        <= Q16_ONE;
      cfg.anchor_pair    <= 64'd0;
      cfg.direction_pair <= 64'd65536;
      cfg.scale_pair     <= 64'd0;
      cfg.ramp_pair      <= 64'd0;
    end else if (wr_en) begin
      case (wr_index)
        REG_X_STEP:    cfg.x_step         <= wr_data[24:0];
        REG_Y_STEP:    cfg.y_step         <= wr_data[24:0];
        REG_MASK_MODE: cfg.mask_mode      <= wr_data[1:0];
        REG_OPACITY:   cfg.opacity        <= wr_data[16:0];
        REG_ANCHOR:    cfg.anchor_pair    <= wr_data;
        REG_DIRECTION: cfg.direction_pair <= wr_data;
        REG_SCALE:     cfg.scale_pair     <= wr_data;
        REG_RAMP:      cfg.ramp_pair      <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/gmcu_geom.sv
// Geometry pipeline: texel centre, offset, rotation, scaling, squares and linear ramp.
module gmcu_geom
  import gmcu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic              in_v,
  input  logic [PIX_W-1:0]  pixel_x,
  input  logic [PIX_W-1:0]  pixel_y,
  input  logic [COV_W-1:0]  prior,
  output logic              out_v,
  output logic [SQ_W-1:0]   radicand,
  output side_t             side
);

  logic v1, v2, v3, v4, v5, v6, v7, v8;
  logic [7:0] pr1, pr2, pr3, pr4, pr5, pr6, pr7, pr8;

  // S1: centre of texel in Q16
  logic [PIX_W-1:0] pxc, pyc;
  logic [37:0] mx, my;
  logic [28:0] nx1, ny1;

  always_comb begin
    pxc = ({1'b0, pixel_x} >= 13'(MAX_RASTER_DIM)) ? PIX_W'(MAX_RASTER_DIM - 1) : pixel_x;
    pyc = ({1'b0, pixel_y} >= 13'(MAX_RASTER_DIM)) ? PIX_W'(MAX_RASTER_DIM - 1) : pixel_y;
    mx = {25'd0, pxc, 1'b1} * {13'd0, cfg.x_step};
    my = {25'd0, pyc, 1'b1} * {13'd0, cfg.y_step};
  end

  // S2: offset from anchor
  logic signed [48:0] dxw, dyw;
  logic signed [31:0] dx2, dy2;
  always_comb begin
    dxw = $signed({20'd0, nx1}) - $signed({{17{cfg.anchor_pair[31]}}, cfg.anchor_pair[31:0]});
    dyw = $signed({20'd0, ny1}) - $signed({{17{cfg.anchor_pair[63]}}, cfg.anchor_pair[63:32]});
  end

  // S3: four rotation products, floored to Q16
  logic signed [31:0] cc, ss;
  logic signed [63:0] m_cx, m_sy, m_cy, m_sx;
  logic signed [47:0] p_cx, p_sy, p_cy, p_sx;
  always_comb begin
    cc   = $signed(cfg.direction_pair[31:0]);
    ss   = $signed(cfg.direction_pair[63:32]);
    m_cx = cc * dx2;
    m_sy = ss * dy2;
    m_cy = cc * dy2;
    m_sx = ss * dx2;
  end

  // S4: rotated coordinates (u doubles as linear distance)
  logic signed [31:0] u4, v4d;

  // S5: scaled by reciprocals
  logic signed [63:0] m_u, m_v;
  logic signed [47:0] pu5, pv5;
  always_comb begin
    m_u = u4 * $signed(cfg.scale_pair[31:0]);
    m_v = v4d * $signed(cfg.scale_pair[63:32]);
  end

  // S6: clamp radii to +-256.0, magnitudes; linear ramp position
  logic [24:0] ax6, ay6;
  logic [16:0] t6;
  logic signed [25:0] rx, ry;
  logic signed [48:0] tl;
  always_comb begin
    if (pu5 > 48'sd16777216) rx = 26'sd16777216;
    else if (pu5 < -48'sd16777216) rx = -26'sd16777216;
    else rx = pu5[25:0];
    if (pv5 > 48'sd16777216) ry = 26'sd16777216;
    else if (pv5 < -48'sd16777216) ry = -26'sd16777216;
    else ry = pv5[25:0];
    tl = $signed({pu5[47], pu5}) + 49'sd32768;
  end

  // S7: squares and ramp interpolation product
  logic [49:0] sx7, sy7;
  logic signed [32:0] es;
  logic signed [50:0] dl7;
  always_comb begin
    es = $signed({cfg.ramp_pair[63], cfg.ramp_pair[63:32]})
       - $signed({cfg.ramp_pair[31], cfg.ramp_pair[31:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= 8'd0;
    end else if (en) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= {in_v, v1, v2, v3, v4, v5, v6, v7};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx1 <= 29'((mx + 38'd256) >> 9);
      ny1 <= 29'((my + 38'd256) >> 9);
      pr1 <= prior;

      dx2 <= sat32(dxw);
      dy2 <= sat32(dyw);
      pr2 <= pr1;

      p_cx <= m_cx[63:16];
      p_sy <= m_sy[63:16];
      p_cy <= m_cy[63:16];
      p_sx <= m_sx[63:16];
      pr3  <= pr2;

      u4  <= sat32($signed({p_cx[47], p_cx}) + $signed({p_sy[47], p_sy}));
      v4d <= sat32($signed({p_cy[47], p_cy}) - $signed({p_sx[47], p_sx}));
      pr4 <= pr3;

      pu5 <= m_u[63:16];
      pv5 <= m_v[63:16];
      pr5 <= pr4;

      ax6 <= rx[25] ? 25'(-rx) : rx[24:0];
      ay6 <= ry[25] ? 25'(-ry) : ry[24:0];
      if (tl < 49'sd0) t6 <= 17'd0;
      else if (tl > 49'sd65536) t6 <= Q16_ONE;
      else t6 <= tl[16:0];
      pr6 <= pr5;

      sx7 <= {25'd0, ax6} * {25'd0, ax6};
      sy7 <= {25'd0, ay6} * {25'd0, ay6};
      dl7 <= 51'(es * $signed({1'b0, t6}));
      pr7 <= pr6;

      radicand     <= sx7 + sy7;
      side.lin_cov <= $signed({{3{cfg.ramp_pair[31]}}, cfg.ramp_pair[31:0]}) + dl7[50:16];
      side.prior   <= pr7;
      pr8          <= pr7;
    end
  end

  assign out_v = v8 && (pr8 == side.prior);

endmodule

FILE: src/gmcu_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side data.
module gmcu_sqrt
  import gmcu_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_v,
  input  logic [SQ_W-1:0] radicand,
  input  side_t           in_side,
  output logic            out_v,
  output logic [RT_W-1:0] root,
  output side_t           out_side
);

  logic            vq   [RT_W];
  logic [29:0]     remq [RT_W];
  logic [RT_W-1:0] rootq[RT_W];
  logic [SQ_W-1:0] valq [RT_W];
  side_t           sideq[RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    logic            v_in;
    logic [29:0]     rem_in, rem_sh, trial;
    logic [RT_W-1:0] root_in;
    logic [SQ_W-1:0] val_in;
    side_t           side_in;
    logic            fits;

    if (k == 0) begin : g_first
      assign v_in    = in_v;
      assign rem_in  = 30'd0;
      assign root_in = '0;
      assign val_in  = radicand;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vq[k-1];
      assign rem_in  = remq[k-1];
      assign root_in = rootq[k-1];
      assign val_in  = valq[k-1];
      assign side_in = sideq[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[27:0], val_in[SQ_W-1 -: 2]};
      trial  = {3'd0, root_in, 2'b01};
      fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) vq[k] <= 1'b0;
      else if (en) vq[k] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remq[k]  <= fits ? rem_sh - trial : rem_sh;
        rootq[k] <= {root_in[RT_W-2:0], fits};
        valq[k]  <= {val_in[SQ_W-3:0], 2'b00};
        sideq[k] <= side_in;
      end
    end
  end

  assign out_v    = vq[RT_W-1];
  assign root     = rootq[RT_W-1];
  assign out_side = sideq[RT_W-1];

endmodule

FILE: src/gmcu_shade.sv
// Feather ramp, mode select, inversion, opacity, byte rounding and max merge.
module gmcu_shade
  import gmcu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  cfg_t             cfg,
  input  logic             in_v,
  input  logic [RT_W-1:0]  rho,
  input  side_t            side,
  output logic             out_v,
  output logic [COV_W-1:0] merged,
  output logic [COV_W-1:0] mask
);

  logic v1, v2, v3, v4;
  side_t s1, s2, s3;
  logic [7:0] pr4;

  // T1: distance past inner edge
  logic signed [48:0] dw;
  logic signed [31:0] d1;
  assign dw = $signed({24'd0, rho})
            - $signed({{17{cfg.ramp_pair[31]}}, cfg.ramp_pair[31:0]});

  // T2: times feather reciprocal
  logic signed [63:0] md;
  logic signed [47:0] pd2;
  assign md = d1 * $signed(cfg.ramp_pair[63:32]);

  // T3: select, invert, clamp to [0, 1.0] in Q32 terms
  logic [16:0] t3, rad;
  logic signed [35:0] cov, covi;
  logic [32:0] cc3;
  always_comb begin
    if (pd2 < 48'sd0) t3 = 17'd0;
    else if (pd2 > 48'sd65536) t3 = Q16_ONE;
    else t3 = pd2[16:0];
    rad  = Q16_ONE - t3;
    cov  = cfg.mask_mode[0] ? $signed({s2.lin_cov[34], s2.lin_cov}) : $signed({19'd0, rad});
    covi = cfg.mask_mode[1] ? $signed({19'd0, Q16_ONE}) - cov : cov;
    if (covi < 36'sd0) cc3 = 33'd0;
    else if (covi > $signed({3'd0, Q32_ONE})) cc3 = Q32_ONE;
    else cc3 = covi[32:0];
  end

  // T4: opacity product
  logic [32:0] cc;
  logic [49:0] prod4;

  // T5: clamp, scale to 255 with half-up rounding, merge
  logic [32:0] ps;
  logic [40:0] sc;
  logic [7:0]  byte_v;
  always_comb begin
    ps     = (prod4 > {17'd0, Q32_ONE}) ? Q32_ONE : prod4[32:0];
    sc     = {ps, 8'd0} - {8'd0, ps} + 41'h0_8000_0000;
    byte_v = sc[39:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, out_v} <= 5'd0;
    end else if (en) begin
      {v1, v2, v3, v4, out_v} <= {in_v, v1, v2, v3, v4};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1    <= sat32(dw);
      s1    <= side;
      pd2   <= md[63:16];
      s2    <= s1;
      cc    <= cc3;
      s3    <= s2;
      prod4 <= {17'd0, cc} * {33'd0, cfg.opacity};
      pr4   <= s3.prior;
      mask   <= byte_v;
      merged <= (pr4 > byte_v) ? pr4 : byte_v;
    end
  end

  a_merge_ge_mask: assert property (@(posedge clk) disable iff (rst)
    out_v |-> merged >= mask)
    else $error("merged coverage below mask coverage");

  a_full_mask_full_merge: assert property (@(posedge clk) disable iff (rst)
    out_v && (mask == 8'd255) |-> merged == 8'd255)
    else $error("full mask did not saturate merged coverage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({v1, v2, v3, v4, out_v}))
    else $error("pipeline valids moved during stall");

endmodule

FILE: src/gradient_mask_coverage_union_top.sv
// Top level of the gradient mask coverage union block.
//
// One texel beat in on pixel_in (pixel_x, pixel_y, prior_coverage), one
// coverage beat out on coverage_out (merged_coverage, mask_coverage), both
// valid/ready. The mask is set up through the write port (wr_en, wr_index,
// wr_data); write registers only while no beat is in flight (not enforced).
//
// Throughput: one texel per cycle unless the output stalls. The path has
// 8 geometry stages, a 25-stage square root (one root bit per stage) and 5
// shading stages, the last of which is the output register.
//
// A stalled receiver freezes the whole pipeline in place; pixel_in.ready
// stays high as long as the output register is empty or being taken, so
// nothing is dropped or repeated. Reset clears every stage valid and loads
// the register defaults (radial mask, unit opacity, identity rotation).
module gradient_mask_coverage_union_top
  import gmcu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data,
  gmcu_in_if.sink     pixel_in,
  gmcu_out_if.source  coverage_out
);

  cfg_t cfg;
  logic en;
  logic g_v, s_v, o_v;
  logic [SQ_W-1:0] radicand;
  logic [RT_W-1:0] rho;
  side_t g_side, s_side;
  logic [COV_W-1:0] merged, mask;

  assign en             = !o_v || coverage_out.ready;
  assign pixel_in.ready = en;

  gmcu_cfg u_cfg (
    .clk, .rst, .wr_en, .wr_index, .wr_data, .cfg
  );

  gmcu_geom u_geom (
    .clk, .rst, .en, .cfg,
    .in_v     (pixel_in.valid),
    .pixel_x  (pixel_in.pixel_x),
    .pixel_y  (pixel_in.pixel_y),
    .prior    (pixel_in.prior_coverage),
    .out_v    (g_v),
    .radicand (radicand),
    .side     (g_side)
  );

  gmcu_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_v     (g_v),
    .radicand (radicand),
    .in_side  (g_side),
    .out_v    (s_v),
    .root     (rho),
    .out_side (s_side)
  );

  gmcu_shade u_shade (
    .clk, .rst, .en, .cfg,
    .in_v   (s_v),
    .rho    (rho),
    .side   (s_side),
    .out_v  (o_v),
    .merged (merged),
    .mask   (mask)
  );

  assign coverage_out.valid           = o_v;
  assign coverage_out.merged_coverage = merged;
  assign coverage_out.mask_coverage   = mask;

endmodule
